/* src/cipg_pkg.sv */
// Package for the console I/O port glue: request/result payload types,
// port group codes and keypad code table. No dependencies.

package cipg_pkg;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Port groups, port[7:5]
    localparam logic [2:0] GRP_MAP    = 3'd3;
    localparam logic [2:0] GRP_MODE_J = 3'd4;
    localparam logic [2:0] GRP_MODE_K = 3'd6;
    localparam logic [2:0] GRP_PAD    = 3'd7;

    localparam logic [7:0] OPEN_BUS   = 8'hFF;
    localparam logic [7:0] JOY_BASE   = 8'h30;

    localparam int NUM_KEYS = 12;

    typedef struct packed {
        logic        command;
        logic [7:0]  port;
        logic [7:0]  write_data;
        logic [15:0] pad_a_state;
        logic [15:0] pad_b_state;
        logic [11:0] keys_a;
        logic [11:0] keys_b;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] page0_slot;
        logic [1:0] page1_slot;
        logic [1:0] page2_slot;
        logic [1:0] page3_slot;
    } t_out;

    // Keypad codes in key order 0..9, star, hash
    function automatic logic [3:0] key_code(input logic [3:0] idx);
        logic [3:0] code;
        case (idx)
            4'd0:    code = 4'hA;
            4'd1:    code = 4'hD;
            4'd2:    code = 4'h7;
            4'd3:    code = 4'hC;
            4'd4:    code = 4'h2;
            4'd5:    code = 4'h3;
            4'd6:    code = 4'hE;
            4'd7:    code = 4'h5;
            4'd8:    code = 4'h1;
            4'd9:    code = 4'hB;
            4'd10:   code = 4'h9;
            4'd11:   code = 4'h6;
            default: code = 4'h0;
        endcase
        return code;
    endfunction

    // Memory-map byte to packed page slots (page i in bits 2i+1..2i)
    function automatic logic [7:0] decode_banks(input logic [7:0] v);
        logic [7:0] lo;
        logic [7:0] hi;
        if (!v[0])      lo = 8'h00;
        else if (!v[1]) lo = 8'h05;
        else if (!v[2]) lo = 8'h0F;
        else            lo = 8'h0A;
        if (!v[3])      hi = 8'h50;
        else if (!v[4]) hi = 8'hA0;
        else if (!v[5]) hi = 8'hF0;
        else            hi = 8'h00;
        return lo | hi;
    endfunction

endpackage

/* src/cipg_pad_read.sv */
// Controller read remap: joystick bits, or fire bits plus keypad code.
// Depends on cipg_pkg.

module cipg_pad_read (
    input  logic        i_joy_mode,
    input  logic [15:0] i_state,
    input  logic [11:0] i_keys,
    output logic [7:0]  o_data
);
    import cipg_pkg::*;

    logic [11:0] lowest;
    logic [3:0]  code;
    logic [7:0]  joy;
    logic [7:0]  fire;

    // Isolate lowest pressed key, then OR in its code
    assign lowest = i_keys & (~i_keys + 12'd1);

    always_comb begin
        code = 4'h0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (lowest[i]) begin
                code = code | key_code(4'(i));
            end
        end
    end

    // Joystick mode layout
    assign joy = JOY_BASE
               | {1'b0, i_state[4], 1'b0, i_state[8],
                  i_state[2], i_state[1], i_state[3], i_state[0]};

    // Keypad mode fire bits
    always_comb begin
        fire = {1'b0, i_state[5], i_state[9], i_state[8], 4'h0};
        if (i_state[6]) fire = fire | 8'h0D;
        if (i_state[7]) fire = fire | 8'h0B;
    end

    assign o_data = i_joy_mode ? joy : (fire | {4'h0, code});

endmodule

/* src/cipg_port_ctrl.sv */
// Port decode and state: memory-map register, page slots, controller mode.
// Depends on cipg_pkg and cipg_pad_read.

module cipg_port_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  cipg_pkg::t_in  i_req,
    output cipg_pkg::t_out o_result
);
    import cipg_pkg::*;

    logic [7:0] r_map;
    logic [7:0] r_slots;
    logic       r_joy_mode;
    logic [7:0] n_map;
    logic [7:0] n_slots;
    logic       n_joy_mode;

    logic [2:0]  group;
    logic        pad_sel;
    logic [15:0] pad_state;
    logic [11:0] pad_keys;
    logic [7:0]  pad_data;
    logic [7:0]  rd;

    assign group     = i_req.port[7:5];
    assign pad_sel   = i_req.port[1];
    assign pad_state = pad_sel ? i_req.pad_b_state : i_req.pad_a_state;
    assign pad_keys  = pad_sel ? i_req.keys_b : i_req.keys_a;

    cipg_pad_read u_pad (
        .i_joy_mode (r_joy_mode),
        .i_state    (pad_state),
        .i_keys     (pad_keys),
        .o_data     (pad_data)
    );

    // Next state and read data for the request in the input stage
    always_comb begin
        n_map      = r_map;
        n_slots    = r_slots;
        n_joy_mode = r_joy_mode;
        rd         = OPEN_BUS;
        if (i_req.command == CMD_WRITE) begin
            rd = 8'h00;
            if (group == GRP_MAP) begin
                n_map   = i_req.write_data;
                n_slots = decode_banks(i_req.write_data);
            end else if (group == GRP_MODE_J || group == GRP_MODE_K) begin
                n_joy_mode = i_req.port[6];
            end
        end else begin
            if (group == GRP_MAP) begin
                rd = r_map;
            end else if (group == GRP_PAD) begin
                rd = pad_data;
            end
        end
    end

    // State commits when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map      <= 8'h00;
            r_slots    <= 8'h00;
            r_joy_mode <= 1'b0;
        end else if (i_adv) begin
            r_map      <= n_map;
            r_slots    <= n_slots;
            r_joy_mode <= n_joy_mode;
        end
    end

    // Slots reported after this request's update
    assign o_result.read_data  = rd;
    assign o_result.page0_slot = n_slots[1:0];
    assign o_result.page1_slot = n_slots[3:2];
    assign o_result.page2_slot = n_slots[5:4];
    assign o_result.page3_slot = n_slots[7:6];

endmodule

/* src/console_io_port_glue_top.sv */
// Channel   | valid       | ready       | payload
// ----------+-------------+-------------+--------------------------
// request   | i_in_valid  | o_in_ready  | i_in_data  (cipg_pkg::t_in)
// result    | o_out_valid | i_out_ready | o_out_data (cipg_pkg::t_out)
//
// One request per cycle sustained while results are taken; a request passes
// the input register, decode and the result register. Map/mode state commits
// as a request enters the result register. A stalled result holds while the
// input register still takes one more request. Synchronous reset empties both
// stages and clears the map register, page slots and controller mode.
// Depends on cipg_pkg and cipg_port_ctrl.

module console_io_port_glue_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cipg_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cipg_pkg::t_out o_out_data
);
    import cipg_pkg::*;

    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;
    t_out result;
    logic adv;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    cipg_port_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_req    (r_in),
        .o_result (result)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

/* src/cipg_checker.sv */
// Port-level checks for console_io_port_glue_top, attached by bind.
// Depends on cipg_pkg.

module cipg_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input cipg_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input cipg_pkg::t_out o_out_data
);
    import cipg_pkg::*;

    // Stalled request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("request changed while stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Bank decode always maps pages in pairs
    a_page_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.page0_slot == o_out_data.page1_slot)
                     && (o_out_data.page2_slot == o_out_data.page3_slot))
        else $error("page slots not paired");

    // An empty result stage never blocks requests
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with result stage empty");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind console_io_port_glue_top cipg_checker u_cipg_checker (.*);

/* tb/console_io_port_glue_top_tb.sv */
// Testbench for console_io_port_glue_top: directed and random port accesses,
// checked against an internal model of the map register, page slots and pad mode.
// Depends on cipg_pkg and the console_io_port_glue_top RTL.

module console_io_port_glue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cipg_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int DRAIN_CYCLES = 8;
    // Keypad codes, key 0 in the low nibble up to hash in the high nibble
    localparam logic [47:0] KEY_CODES = {4'h6, 4'h9, 4'hB, 4'h1, 4'h5, 4'hE,
                                         4'h3, 4'h2, 4'hC, 4'h7, 4'hD, 4'hA};

    // Model of the port glue state plus the queue of pending results
    class port_glue_scoreboard;
        logic [7:0] map_reg;
        logic [7:0] slots;
        logic       joy_mode;
        t_out       expected_q[$];
        int         errors;
        int         results_checked;

        function new();
            map_reg         = 8'h00;
            slots           = 8'h00;
            joy_mode        = 1'b0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function logic [7:0] bank_slots(input logic [7:0] v);
            logic [7:0] lo;
            logic [7:0] hi;
            casez (v[2:0])
                3'b??0:  lo = 8'h00;
                3'b?01:  lo = 8'h05;
                3'b011:  lo = 8'h0F;
                default: lo = 8'h0A;
            endcase
            casez (v[5:3])
                3'b??0:  hi = 8'h50;
                3'b?01:  hi = 8'hA0;
                3'b011:  hi = 8'hF0;
                default: hi = 8'h00;
            endcase
            return lo | hi;
        endfunction

        function logic [7:0] controller_byte(input logic [15:0] st, input logic [11:0] keys);
            logic [7:0] v;
            bit         found;
            found = 0;
            if (joy_mode) begin
                // bits 5:4 are always set in joystick mode
                return {1'b0, st[4], 2'b11, st[2], st[1], st[3], st[0]};
            end
            v = {1'b0, st[5], st[9], st[8], 4'h0};
            if (st[6]) v = v | 8'h0D;
            if (st[7]) v = v | 8'h0B;
            // lowest pressed key wins
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (keys[i] && !found) begin
                    v     = v | {4'h0, KEY_CODES[4*i +: 4]};
                    found = 1;
                end
            end
            return v;
        endfunction

        function t_out apply_access(input t_in r);
            t_out       res;
            logic [2:0] grp;
            logic [7:0] rd;
            grp = r.port[7:5];
            rd  = OPEN_BUS;
            if (r.command == CMD_WRITE) begin
                rd = 8'h00;
                if (grp == GRP_MAP) begin
                    map_reg = r.write_data;
                    slots   = bank_slots(r.write_data);
                end else if (grp == GRP_MODE_J || grp == GRP_MODE_K) begin
                    joy_mode = r.port[6];
                end
            end else begin
                if (grp == GRP_MAP)
                    rd = map_reg;
                else if (grp == GRP_PAD)
                    rd = r.port[1] ? controller_byte(r.pad_b_state, r.keys_b)
                                   : controller_byte(r.pad_a_state, r.keys_a);
            end
            res.read_data  = rd;
            res.page0_slot = slots[1:0];
            res.page1_slot = slots[3:2];
            res.page2_slot = slots[5:4];
            res.page3_slot = slots[7:6];
            return res;
        endfunction

        function void note_request(input t_in r);
            expected_q.push_back(apply_access(r));
        endfunction

        function void compare_field(input string field, input logic [7:0] exp_v,
                                    input logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, actual %h", field, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(input t_out got);
            t_out exp_r;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: %p", got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            results_checked++;
            compare_field("read_data", exp_r.read_data, got.read_data);
            compare_field("page0_slot", {6'd0, exp_r.page0_slot}, {6'd0, got.page0_slot});
            compare_field("page1_slot", {6'd0, exp_r.page1_slot}, {6'd0, got.page1_slot});
            compare_field("page2_slot", {6'd0, exp_r.page2_slot}, {6'd0, got.page2_slot});
            compare_field("page3_slot", {6'd0, exp_r.page3_slot}, {6'd0, got.page3_slot});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    logic out_ready  = 1'b0;
    t_in  in_data    = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    port_glue_scoreboard sb = new();

    console_io_port_glue_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly back to back, some short gaps, a few long ones
    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    function logic [15:0] random_pad();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'hFFFF;
        if (r < 15) return 16'h0000;
        return 16'($urandom);
    endfunction

    // Sparse key patterns so that every key gets to win the priority
    function logic [11:0] random_keys();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 12'(1) << $urandom_range(11);
        if (r < 60) return 12'($urandom) & 12'($urandom) & 12'($urandom);
        if (r < 80) return 12'($urandom);
        if (r < 92) return 12'h000;
        return 12'hFFF;
    endfunction

    function t_in make_access(input logic cmd, input logic [7:0] prt, input logic [7:0] data);
        t_in r;
        r.command     = cmd;
        r.port        = prt;
        r.write_data  = data;
        r.pad_a_state = random_pad();
        r.pad_b_state = random_pad();
        r.keys_a      = random_keys();
        r.keys_b      = random_keys();
        return r;
    endfunction

    function t_in random_access();
        int         r;
        logic [7:0] prt;
        logic       cmd;
        r   = $urandom_range(99);
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        if (r < 30) begin
            prt = {GRP_PAD, 5'($urandom)};
            cmd = ($urandom_range(99) < 80) ? CMD_READ : CMD_WRITE;
        end else if (r < 45) begin
            prt = {GRP_MAP, 5'($urandom)};
        end else if (r < 60) begin
            prt = {($urandom_range(1) ? GRP_MODE_J : GRP_MODE_K), 5'($urandom)};
        end else begin
            prt = 8'($urandom);
        end
        return make_access(cmd, prt, 8'($urandom));
    endfunction

    // Offer one request after an optional gap; returns at the accepting edge
    task automatic send_request(input t_in req, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    // Result side: random stalls, a quiet stretch and one long hold-off
    int  hold_left     = 0;
    int  stall_left    = 0;
    bit  pressure_done = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && out_ready)
                sb.check_result(o_out_data);
            if (!pressure_done && sb.results_checked >= 300) begin
                hold_left     = 250;
                pressure_done = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (sb.results_checked >= 500 && sb.results_checked < 620) begin
                out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if ($urandom_range(99) < 25) begin
                stall_left = ($urandom_range(99) < 90) ? $urandom_range(2, 0)
                                                       : $urandom_range(40, 10);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long with no request or result moving
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        t_in req;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: map register, bank decode, open bus, pad reads in both modes
        send_request(make_access(CMD_READ,  8'h60, 8'h00), 0);
        send_request(make_access(CMD_READ,  8'h20, 8'h00), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h3F, 8'hA5), pick_gap());
        send_request(make_access(CMD_READ,  8'h3F, 8'hFF), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h7F, 8'h00), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h60, 8'h01), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h6A, 8'h03), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h60, 8'h07), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h60, 8'h0F), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h60, 8'h1F), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h60, 8'h3F), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h60, 8'hFF), pick_gap());
        send_request(make_access(CMD_READ,  8'h7F, 8'h00), pick_gap());
        send_request(make_access(CMD_READ,  8'h80, 8'h00), pick_gap());
        send_request(make_access(CMD_READ,  8'hC0, 8'h00), pick_gap());
        // keypad mode: no key, hash only, star only, all keys
        req = make_access(CMD_READ, 8'hE0, 8'h00);
        req.pad_a_state = 16'hFFFF;
        req.keys_a      = 12'h000;
        send_request(req, pick_gap());
        req = make_access(CMD_READ, 8'hE2, 8'h00);
        req.pad_b_state = 16'h0000;
        req.keys_b      = 12'h800;
        send_request(req, pick_gap());
        req = make_access(CMD_READ, 8'hE1, 8'h00);
        req.pad_a_state = 16'h0000;
        req.keys_a      = 12'h400;
        send_request(req, pick_gap());
        req = make_access(CMD_READ, 8'hFF, 8'h00);
        req.pad_b_state = 16'h00C0;
        req.keys_b      = 12'hFFF;
        send_request(req, pick_gap());
        // joystick mode reads, then back to keypad mode
        send_request(make_access(CMD_WRITE, 8'hDF, 8'h00), pick_gap());
        req = make_access(CMD_READ, 8'hE0, 8'h00);
        req.pad_a_state = 16'hFFFF;
        send_request(req, pick_gap());
        req = make_access(CMD_READ, 8'hFE, 8'h00);
        req.pad_b_state = 16'h0000;
        send_request(req, pick_gap());
        send_request(make_access(CMD_WRITE, 8'h9F, 8'h00), pick_gap());
        send_request(make_access(CMD_WRITE, 8'hE0, 8'h55), pick_gap());
        send_request(make_access(CMD_READ,  8'h00, 8'h00), pick_gap());
        send_request(make_access(CMD_WRITE, 8'h00, 8'hFF), pick_gap());

        // Random traffic, with a stretch of back-to-back requests
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_request(random_access(), (i >= 500 && i < 620) ? 0 : pick_gap());
        in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
